>>> hdl/u16u8_pkg.sv
package u16u8_pkg;

  // Depth of the job queue between front and back.
  localparam int unsigned JobQueueDepth = 2;

  // Surrogate prefixes and the offset of the supplementary planes.
  localparam logic [5:0]  HighSurrPrefix = 6'b110110;
  localparam logic [5:0]  LowSurrPrefix  = 6'b110111;
  localparam logic [20:0] SuppOffset     = 21'h10000;

  // Number of UTF-8 bytes of one code point (0 means none).
  typedef logic [2:0] byte_len_t;
  localparam byte_len_t LenNone  = 3'd0;
  localparam byte_len_t LenOne   = 3'd1;
  localparam byte_len_t LenTwo   = 3'd2;
  localparam byte_len_t LenThree = 3'd3;
  localparam byte_len_t LenFour  = 3'd4;

  // One unit of work for the back end: an optional flushed high surrogate,
  // followed by an optional code point.
  typedef struct packed {
    logic        flush_en;
    logic [9:0]  flush_bits;
    byte_len_t   cp_len;
    logic [20:0] cp;
  } job_t;

  // Byte count for a code point below 0x10000.
  function automatic byte_len_t bmp_len(input logic [15:0] unit);
    byte_len_t len;
    if (unit[15:7] == '0) begin
      len = LenOne;
    end else if (unit[15:11] == '0) begin
      len = LenTwo;
    end else begin
      len = LenThree;
    end
    return len;
  endfunction

  // One byte of the UTF-8 encoding of cp, which is len bytes long.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input byte_len_t len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len)
      LenOne: b = {1'b0, cp[6:0]};
      LenTwo: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LenThree: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LenFour: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = {2'b10, cp[5:0]};
    endcase
    return b;
  endfunction

endpackage

>>> hdl/u16u8_if.sv
// Channel of UTF-16 code units.
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

// Channel of UTF-8 bytes.
interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> hdl/u16u8_front.sv
module u16u8_front (
  input  logic               clk,
  input  logic               rst,
  u16u8_unit_if.sink         utf16,
  input  logic               queue_ready,
  output logic               push,
  output u16u8_pkg::job_t    job
);

  logic       holding_high;
  logic [9:0] held_high_bits;
  logic       is_high;
  logic       is_low;
  logic       accept;

  assign utf16.ready = queue_ready;
  assign accept      = utf16.valid && queue_ready;

  // Classify the incoming unit.
  assign is_high = (utf16.code_unit[15:10] == u16u8_pkg::HighSurrPrefix);
  assign is_low  = (utf16.code_unit[15:10] == u16u8_pkg::LowSurrPrefix);

  // Build the job that this unit causes.
  always_comb begin
    job.flush_en   = holding_high && !is_low;
    job.flush_bits = held_high_bits;
    job.cp_len     = u16u8_pkg::bmp_len(utf16.code_unit);
    job.cp         = {5'd0, utf16.code_unit};
    if (holding_high && is_low) begin
      job.cp_len = u16u8_pkg::LenFour;
      job.cp     = {1'b0, held_high_bits, utf16.code_unit[9:0]} + u16u8_pkg::SuppOffset;
    end else if (is_high && !utf16.end_of_string) begin
      job.cp_len = u16u8_pkg::LenNone;
    end
  end

  // A unit that is only held produces no job.
  assign push = accept && (job.flush_en || (job.cp_len != u16u8_pkg::LenNone));

  // Held surrogate state.
  always_ff @(posedge clk) begin
    if (rst) begin
      holding_high   <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      if (is_high && !utf16.end_of_string && !(holding_high && is_low)) begin
        holding_high   <= 1'b1;
        held_high_bits <= utf16.code_unit[9:0];
      end else begin
        holding_high   <= 1'b0;
        held_high_bits <= '0;
      end
    end
  end

endmodule

>>> hdl/u16u8_queue.sv
module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::JobQueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output u16u8_pkg::job_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u16u8_pkg::job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign not_full  = (count != CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/u16u8_back.sv
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_avail,
  input  u16u8_pkg::job_t next_job,
  output logic            pop,
  u16u8_byte_if.source    utf8
);

  u16u8_pkg::job_t     cur;
  logic                busy;
  logic                in_flush;
  logic [1:0]          idx;
  logic [20:0]         part_cp;
  u16u8_pkg::byte_len_t part_len;
  logic                part_last;
  logic                job_last;
  logic                fire;

  // Select the code point being sent: the flushed surrogate comes first.
  assign part_cp  = in_flush ? {5'd0, u16u8_pkg::HighSurrPrefix, cur.flush_bits} : cur.cp;
  assign part_len = in_flush ? u16u8_pkg::LenThree : cur.cp_len;

  assign part_last = ({1'b0, idx} == part_len - 3'd1);
  assign job_last  = part_last && (!in_flush || cur.cp_len == u16u8_pkg::LenNone);

  assign utf8.valid       = busy;
  assign utf8.out_byte    = u16u8_pkg::enc_byte(part_cp, part_len, idx);
  assign utf8.last_of_run = job_last;

  assign fire = busy && utf8.ready;
  assign pop  = job_avail && (!busy || (fire && job_last));

  // Byte sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      in_flush <= 1'b0;
      idx      <= '0;
    end else if (pop) begin
      busy     <= 1'b1;
      in_flush <= next_job.flush_en;
      idx      <= '0;
    end else if (fire) begin
      if (job_last) begin
        busy <= 1'b0;
      end else if (part_last) begin
        in_flush <= 1'b0;
        idx      <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Current job payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= next_job;
    end
  end

endmodule

>>> hdl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// Input channel utf16 carries one code unit per transaction, with
// end_of_string set on the last unit of a string. Output channel utf8
// carries one UTF-8 byte per transaction; last_of_run marks the final
// byte caused by one input unit. A high surrogate is held until the next
// unit; it pairs with a following low surrogate into four bytes, and is
// otherwise sent alone as three bytes. A high surrogate that ends the
// string is sent at once. Both channels use valid/ready.
// The first byte of a unit passes through the job queue and the job
// register of the back end before it appears. Throughput is one byte per
// cycle while the receiver is ready, set by the byte sequencer in the back
// end: a unit gives 1 to 3 bytes, a surrogate pair 4, and a flushed surrogate plus a new unit up to 6.
// A held high surrogate gives no output bytes. A job queue of
// QueueDepth entries lets the front keep taking units while the receiver
// stalls; utf16.ready falls only once the queue is full.
// Reset (rst, synchronous) empties the queue and drops any held surrogate.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = u16u8_pkg::JobQueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  u16u8_unit_if.sink    utf16,
  u16u8_byte_if.source  utf8
);

  logic            push;
  logic            not_full;
  logic            not_empty;
  logic            pop;
  u16u8_pkg::job_t push_job;
  u16u8_pkg::job_t head;

  // Classify units and track the held surrogate.
  u16u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .utf16       (utf16),
    .queue_ready (not_full),
    .push        (push),
    .job         (push_job)
  );

  // Jobs waiting for the byte sequencer.
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Send the bytes of each job.
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (not_empty),
    .next_job  (head),
    .pop       (pop),
    .utf8      (utf8)
  );

endmodule

>>> tb/sv/tb_utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;

  localparam int unsigned RandomUnits = 400;
  localparam int unsigned IdlePercent = 36;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned DirectedCount = 26;

  // Surrogate ranges and the base of the supplementary planes.
  localparam logic [15:0] HighSurrFirst = 16'hD800;
  localparam logic [15:0] HighSurrLast  = 16'hDBFF;
  localparam logic [15:0] LowSurrFirst  = 16'hDC00;
  localparam logic [15:0] LowSurrLast   = 16'hDFFF;
  localparam logic [20:0] PlaneOneBase  = 21'h10000;

  // One expected UTF-8 byte.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  // One directed code unit. Where typed is set, the expected bytes are
  // given in the row, first byte in the most significant position.
  typedef struct {
    logic [15:0] unit;
    logic        eos;
    bit          typed;
    int unsigned count;
    logic [47:0] bytes;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  u16u8_unit_if unit_ch ();
  u16u8_byte_if byte_ch ();

  utf16_to_utf8_transcoder dut (
    .clk   (clk),
    .rst   (rst),
    .utf16 (unit_ch),
    .utf8  (byte_ch)
  );

  // Surrogate pairing state of the predictor.
  logic [9:0] pending_high_bits = '0;
  logic       pending_high = 1'b0;

  logic [7:0]  unit_bytes [$];
  utf8_byte_t  expected_bytes [$];

  int unsigned units_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_receiver = 1'b0;

  stim_row_t directed_rows [DirectedCount] = '{
    '{16'h0000, 1'b0, 1'b1, 1, 48'h00},
    '{16'h007F, 1'b0, 1'b1, 1, 48'h7F},
    '{16'h0080, 1'b0, 1'b1, 2, 48'hC280},
    '{16'h07FF, 1'b0, 1'b1, 2, 48'hDFBF},
    '{16'h0800, 1'b0, 1'b1, 3, 48'hE0A080},
    '{16'hFFFF, 1'b1, 1'b1, 3, 48'hEFBFBF},
    // Lowest pair and highest pair.
    '{16'hD800, 1'b0, 1'b1, 0, 48'h0},
    '{16'hDC00, 1'b0, 1'b1, 4, 48'hF0908080},
    '{16'hDBFF, 1'b0, 1'b1, 0, 48'h0},
    '{16'hDFFF, 1'b1, 1'b1, 4, 48'hF48FBFBF},
    // Low surrogates with nothing held.
    '{16'hDC00, 1'b0, 1'b1, 3, 48'hEDB080},
    '{16'hDFFF, 1'b1, 1'b1, 3, 48'hEDBFBF},
    // High surrogate that ends the string goes out at once.
    '{16'hD800, 1'b1, 1'b1, 3, 48'hEDA080},
    // Held high surrogate broken by a BMP unit: six bytes in one run.
    '{16'hDBFF, 1'b0, 1'b1, 0, 48'h0},
    '{16'hFFFF, 1'b1, 1'b1, 6, 48'hEDAFBFEFBFBF},
    // Held high surrogate followed by another high one, which is held.
    '{16'hD800, 1'b0, 1'b1, 0, 48'h0},
    '{16'hDBFF, 1'b0, 1'b1, 3, 48'hEDA080},
    '{16'hDFFF, 1'b1, 1'b1, 4, 48'hF48FBFBF},
    '{16'hD834, 1'b0, 1'b0, 0, 48'h0},
    '{16'hD834, 1'b1, 1'b0, 0, 48'h0},
    '{16'hD83D, 1'b0, 1'b0, 0, 48'h0},
    '{16'hDE00, 1'b1, 1'b0, 0, 48'h0},
    '{16'h00E9, 1'b0, 1'b0, 0, 48'h0},
    '{16'h20AC, 1'b0, 1'b0, 0, 48'h0},
    '{16'hD7FF, 1'b0, 1'b0, 0, 48'h0},
    '{16'hE000, 1'b1, 1'b0, 0, 48'h0}
  };

  // Appends the UTF-8 bytes of one code point to unit_bytes.
  function automatic void encode_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      unit_bytes.push_back(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      unit_bytes.push_back(8'hC0 | {3'b000, cp[10:6]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      unit_bytes.push_back(8'hE0 | {4'h0, cp[15:12]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
    end else begin
      unit_bytes.push_back(8'hF0 | {5'b00000, cp[20:18]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[17:12]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
      unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  // Works out the bytes caused by one code unit and updates the pairing state.
  function automatic void predict_unit(input logic [15:0] unit, input logic eos);
    logic is_high;
    logic is_low;
    is_high = (unit >= HighSurrFirst) && (unit <= HighSurrLast);
    is_low  = (unit >= LowSurrFirst) && (unit <= LowSurrLast);
    unit_bytes.delete();
    if (pending_high && is_low) begin
      encode_code_point({1'b0, pending_high_bits, unit[9:0]} + PlaneOneBase);
      pending_high = 1'b0;
      pending_high_bits = '0;
      return;
    end
    // A held high surrogate that is not paired goes out on its own.
    if (pending_high) begin
      encode_code_point({5'b00000, HighSurrFirst | {6'b000000, pending_high_bits}});
      pending_high = 1'b0;
      pending_high_bits = '0;
    end
    if (is_high && !eos) begin
      pending_high_bits = unit[9:0];
      pending_high = 1'b1;
    end else begin
      encode_code_point({5'b00000, unit});
    end
  endfunction

  // Offers one code unit, waits for its transaction, then records the bytes
  // it should cause.
  task automatic send_unit(input logic [15:0] unit, input logic eos, input bit typed,
                           input int unsigned count, input logic [47:0] bytes);
    int unsigned idx;
    while (!no_idle && ($urandom_range(99) < IdlePercent)) begin
      unit_ch.valid <= 1'b0;
      @(posedge clk);
    end
    unit_ch.valid <= 1'b1;
    unit_ch.code_unit <= unit;
    unit_ch.end_of_string <= eos;
    do @(posedge clk); while (!unit_ch.ready);
    predict_unit(unit, eos);
    if (typed) begin
      for (idx = 0; idx < count; idx++) begin
        expected_bytes.push_back('{bytes[8 * (count - 1 - idx) +: 8], idx == count - 1});
      end
    end else begin
      for (idx = 0; idx < unit_bytes.size(); idx++) begin
        expected_bytes.push_back('{unit_bytes[idx], idx == unit_bytes.size() - 1});
      end
    end
    units_sent++;
  endtask

  // Builds one string of random characters, mostly well formed, and sends it.
  task automatic send_random_string();
    logic [15:0] units [$];
    int unsigned chars;
    int unsigned pick;
    int unsigned idx;
    chars = $urandom_range(8, 1);
    repeat (chars) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        units.push_back(16'($urandom_range(16'h7F)));
      end else if (pick < 35) begin
        units.push_back(16'($urandom_range(16'h7FF, 16'h80)));
      end else if (pick < 55) begin
        if ($urandom_range(1) == 0) begin
          units.push_back(16'($urandom_range(16'hD7FF, 16'h800)));
        end else begin
          units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
        end
      end else if (pick < 80) begin
        units.push_back(16'($urandom_range(HighSurrLast, HighSurrFirst)));
        units.push_back(16'($urandom_range(LowSurrLast, LowSurrFirst)));
      end else if (pick < 88) begin
        units.push_back(16'($urandom_range(LowSurrLast, LowSurrFirst)));
      end else if (pick < 96) begin
        units.push_back(16'($urandom_range(HighSurrLast, HighSurrFirst)));
      end else begin
        units.push_back(16'($urandom));
      end
    end
    for (idx = 0; idx < units.size(); idx++) begin
      send_unit(units[idx], idx == units.size() - 1, 1'b0, 0, '0);
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    int unsigned held;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        byte_ch.ready <= 1'b0;
        for (held = 1; held < HoldCycles; held++) @(posedge clk);
        hold_receiver = 1'b0;
      end else begin
        byte_ch.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk) begin : byte_checker
    utf8_byte_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected no transaction, actual %02h", byte_ch.out_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (byte_ch.out_byte !== want.value) begin
          $error("out_byte: expected %02h, actual %02h", want.value, byte_ch.out_byte);
          mismatches++;
        end
        if (byte_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, byte_ch.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || (unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random strings.
  initial begin : stimulus
    int unsigned row;
    bit drain_done;
    bit hold_done;
    drain_done = 1'b0;
    hold_done = 1'b0;
    unit_ch.valid <= 1'b0;
    unit_ch.code_unit <= '0;
    unit_ch.end_of_string <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DirectedCount; row++) begin
      send_unit(directed_rows[row].unit, directed_rows[row].eos, directed_rows[row].typed,
                directed_rows[row].count, directed_rows[row].bytes);
    end

    while (units_sent < DirectedCount + RandomUnits) begin
      no_idle = (units_sent >= 120) && (units_sent < 200);
      // Let the block run dry once before going on.
      if (!drain_done && (units_sent >= 220)) begin
        unit_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
        drain_done = 1'b1;
      end
      // Hold the receiver off while units keep coming, to fill the queue.
      if (!hold_done && (units_sent >= 300)) begin
        hold_receiver = 1'b1;
        hold_done = 1'b1;
      end
      send_random_string();
    end
    unit_ch.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
